[hdl/fat_cluster_chain_allocator_core_defines.svh]
// Assertion macros shared by the allocator checker.
`ifndef FAT_CLUSTER_CHAIN_ALLOCATOR_CORE_DEFINES_SVH
`define FAT_CLUSTER_CHAIN_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FCCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define FCCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed: next-cycle implication");

// Next-cycle implication that stays active through reset.
`define FCCA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("allocator check failed: implication across reset");

`endif

[hdl/fcca_pkg.sv]
// Shared types and constants of the cluster chain allocator.
`default_nettype none
package fcca_pkg;

   localparam int unsigned NUM_CLUSTERS_DEFAULT = 4096;
   localparam int unsigned ENTRY_W   = 28;
   localparam int unsigned CLUSTER_W = 12;

   typedef logic [ENTRY_W-1:0]   entry_type;
   typedef logic [CLUSTER_W-1:0] cluster_type;

   typedef enum logic [1:0] {
      FUNC_READ   = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_ALLOC  = 2'd2,
      FUNC_EXTEND = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_BADSTART = 2'd2,
      STAT_RANGE    = 2'd3
   } status_type;

   localparam entry_type EOC_MIN     = 28'hFFFFFF8;
   localparam entry_type EOC_MARK    = 28'hFFFFFFF;
   localparam entry_type MEDIA_ENTRY = 28'hFFFFFF8;

endpackage
`default_nettype wire

[hdl/fcca_if.sv]
// Request and response channel interfaces of the cluster chain allocator.
`default_nettype none
interface fcca_req_if;
   import fcca_pkg::*;
   logic        valid;
   logic        ready;
   func_type    func;
   cluster_type cluster;
   entry_type   value;
   modport source (output valid, output func, output cluster, output value, input ready);
   modport sink   (input valid, input func, input cluster, input value, output ready);
endinterface

interface fcca_rsp_if;
   import fcca_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   entry_type  result;
   modport source (output valid, output status, output result, input ready);
   modport sink   (input valid, input status, input result, output ready);
endinterface
`default_nettype wire

[hdl/fat_cluster_chain_allocator_core.sv]
// FAT32-style cluster allocation table with read, write, allocate and chain extend.
//
// One request enters on req_chan (valid/ready) and yields exactly one response on
// rsp_chan. The block handles one request at a time; req_chan.ready is high only
// while it is idle. A finished response sits in an output register, so the next
// request is taken while that response still waits for rsp_chan.ready.
// The table lives in one synchronous memory with a registered read.
// From acceptance to the response register: a read passes through RDATA, a write
// is done at acceptance, allocate scans entries from the scan start until it
// finds a free one, and extend follows the chain links, then scans, then writes
// the new link in LINK.
// The scan and the chain walk each take one memory read per cycle.
// After reset the block runs a clearing pass over all NUM_CLUSTERS entries that writes
// the formatted table; no request is accepted during it, while csr_we writes to
// scan_start are taken at any time. A stalled receiver only holds the response;
// a completed request waits in its final state until the output register frees.
`default_nettype none
module fat_cluster_chain_allocator_core #(
   parameter int unsigned NUM_CLUSTERS = fcca_pkg::NUM_CLUSTERS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire fcca_pkg::cluster_type csr_wdata,
   fcca_req_if.sink                   req_chan,
   fcca_rsp_if.source                 rsp_chan
);
   import fcca_pkg::*;

   localparam int unsigned AW = $clog2(NUM_CLUSTERS);
   localparam int unsigned SW = $clog2(NUM_CLUSTERS + 1);
   localparam entry_type       NUM_C     = ENTRY_W'(NUM_CLUSTERS);
   localparam logic [AW-1:0]   LAST_ADDR = AW'(NUM_CLUSTERS - 1);
   localparam logic [SW-1:0]   MAX_STEPS = SW'(NUM_CLUSTERS);
   localparam entry_type       TWO       = ENTRY_W'(2);

   typedef enum logic [6:0] {
      STATE_CLEAR = 7'b0000001,
      STATE_IDLE  = 7'b0000010,
      STATE_RDATA = 7'b0000100,
      STATE_WALK  = 7'b0001000,
      STATE_SCAN  = 7'b0010000,
      STATE_LINK  = 7'b0100000,
      STATE_RESP  = 7'b1000000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   cluster_type   scan_start_ff;
   logic          op_ext_ff, op_ext_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [SW-1:0] steps_ff, steps_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [AW-1:0] got_ff, got_in;
   status_type    pend_status_ff, pend_status_in;
   entry_type     pend_result_ff, pend_result_in;
   logic          rsp_valid_ff;
   status_type    rsp_status_ff;
   entry_type     rsp_result_ff;
   logic          rsp_load;

   entry_type     fat_mem_ff [NUM_CLUSTERS];
   entry_type     rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] mem_raddr;

   entry_type     cl_ext;
   entry_type     start_ext;
   entry_type     scan_first;
   logic [AW-1:0] scan_first_addr;
   logic          scan_go;

   assign cl_ext          = ENTRY_W'(req_chan.cluster);
   assign start_ext       = ENTRY_W'(scan_start_ff);
   // The scan never starts below the first data cluster.
   assign scan_first      = (start_ext < TWO) ? TWO : start_ext;
   assign scan_first_addr = scan_first[AW-1:0];

   always_comb begin
      state_in       = state_ff;
      clr_ptr_in     = clr_ptr_ff;
      op_ext_in      = op_ext_ff;
      cur_in         = cur_ff;
      steps_in       = steps_ff;
      ptr_in         = ptr_ff;
      rd_addr_in     = rd_addr_ff;
      got_in         = got_ff;
      pend_status_in = pend_status_ff;
      pend_result_in = pend_result_ff;
      rsp_load       = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = cur_ff;
      mem_wdata      = '0;
      mem_raddr      = ptr_ff;
      scan_go        = 1'b0;

      case (state_ff)
         STATE_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ptr_ff;
            if (clr_ptr_ff == '0) begin
               mem_wdata = MEDIA_ENTRY;
            end else if (clr_ptr_ff == AW'(1) || clr_ptr_ff == AW'(2)) begin
               mem_wdata = EOC_MARK;
            end
            clr_ptr_in = clr_ptr_ff + AW'(1);
            if (clr_ptr_ff == LAST_ADDR) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            if (req_chan.valid) begin
               op_ext_in      = (req_chan.func == FUNC_EXTEND);
               pend_result_in = '0;
               case (req_chan.func)
                  FUNC_READ: begin
                     if (cl_ext >= NUM_C) begin
                        pend_status_in = STAT_RANGE;
                        state_in       = STATE_RESP;
                     end else begin
                        mem_raddr = cl_ext[AW-1:0];
                        state_in  = STATE_RDATA;
                     end
                  end
                  FUNC_WRITE: begin
                     if (cl_ext >= NUM_C) begin
                        pend_status_in = STAT_RANGE;
                     end else begin
                        mem_we         = 1'b1;
                        mem_waddr      = cl_ext[AW-1:0];
                        mem_wdata      = req_chan.value;
                        pend_status_in = STAT_OK;
                     end
                     state_in = STATE_RESP;
                  end
                  FUNC_ALLOC: begin
                     scan_go = 1'b1;
                  end
                  FUNC_EXTEND: begin
                     if (cl_ext < TWO || cl_ext >= NUM_C) begin
                        pend_status_in = STAT_BADSTART;
                        state_in       = STATE_RESP;
                     end else begin
                        cur_in    = cl_ext[AW-1:0];
                        steps_in  = '0;
                        mem_raddr = cl_ext[AW-1:0];
                        state_in  = STATE_WALK;
                     end
                  end
                  default: begin
                     state_in = STATE_IDLE;
                  end
               endcase
            end
         end
         STATE_RDATA: begin
            pend_status_in = STAT_OK;
            pend_result_in = rdata_ff;
            state_in       = STATE_RESP;
         end
         STATE_WALK: begin
            // The next link goes straight back to the read port, one link a cycle.
            if (rdata_ff >= EOC_MIN) begin
               scan_go = 1'b1;
            end else if (rdata_ff < TWO || rdata_ff >= NUM_C || steps_ff >= MAX_STEPS) begin
               pend_status_in = STAT_RANGE;
               pend_result_in = '0;
               state_in       = STATE_RESP;
            end else begin
               cur_in    = rdata_ff[AW-1:0];
               steps_in  = steps_ff + SW'(1);
               mem_raddr = rdata_ff[AW-1:0];
            end
         end
         STATE_SCAN: begin
            // Reads are issued every cycle; rdata_ff belongs to rd_addr_ff.
            mem_raddr  = ptr_ff;
            rd_addr_in = ptr_ff;
            ptr_in     = (ptr_ff == LAST_ADDR) ? ptr_ff : ptr_ff + AW'(1);
            if (rdata_ff == '0) begin
               mem_we    = 1'b1;
               mem_waddr = rd_addr_ff;
               mem_wdata = EOC_MIN;
               got_in    = rd_addr_ff;
               if (op_ext_ff) begin
                  state_in = STATE_LINK;
               end else begin
                  pend_status_in = STAT_OK;
                  pend_result_in = ENTRY_W'(rd_addr_ff);
                  state_in       = STATE_RESP;
               end
            end else if (rd_addr_ff == LAST_ADDR) begin
               pend_status_in = STAT_FULL;
               pend_result_in = '0;
               state_in       = STATE_RESP;
            end
         end
         STATE_LINK: begin
            mem_we         = 1'b1;
            mem_waddr      = cur_ff;
            mem_wdata      = ENTRY_W'(got_ff);
            pend_status_in = STAT_OK;
            pend_result_in = ENTRY_W'(got_ff);
            state_in       = STATE_RESP;
         end
         STATE_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase

      // Start of a free-cluster scan, shared by allocate and extend.
      if (scan_go) begin
         if (scan_first >= NUM_C) begin
            pend_status_in = STAT_FULL;
            pend_result_in = '0;
            state_in       = STATE_RESP;
         end else begin
            mem_raddr  = scan_first_addr;
            rd_addr_in = scan_first_addr;
            ptr_in     = (scan_first_addr == LAST_ADDR) ? scan_first_addr
                                                        : scan_first_addr + AW'(1);
            state_in   = STATE_SCAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fat_mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= fat_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_CLEAR;
         clr_ptr_ff    <= '0;
         scan_start_ff <= CLUSTER_W'(2);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ptr_ff <= clr_ptr_in;
         if (csr_we) begin
            scan_start_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ext_ff      <= op_ext_in;
      cur_ff         <= cur_in;
      steps_ff       <= steps_in;
      ptr_ff         <= ptr_in;
      rd_addr_ff     <= rd_addr_in;
      got_ff         <= got_in;
      pend_status_ff <= pend_status_in;
      pend_result_ff <= pend_result_in;
      if (rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_result_ff <= pend_result_ff;
      end
   end

   assign req_chan.ready  = (state_ff == STATE_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.result = rsp_result_ff;

endmodule
`default_nettype wire

[hdl/fcca_checker.sv]
// Port-level checker of the cluster chain allocator and its bind.
`default_nettype none
`include "fat_cluster_chain_allocator_core_defines.svh"
module fcca_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [27:0] rsp_result
);

   // The clearing pass after reset keeps requests out.
   `FCCA_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clock, reset, !req_ready)

   // One request at a time: an accepted request closes the input at once.
   `FCCA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

   // A rising response valid implies that the block was busy, with req_ready low, just before.
   `FCCA_ASSERT_SAME(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

   // A stalled response holds.
   `FCCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_result))

endmodule

bind fat_cluster_chain_allocator_core fcca_checker u_fcca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_result (rsp_chan.result)
);
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the cluster chain allocator core.
`timescale 1ns / 100ps

import fcca_pkg::*;

typedef struct packed {
   status_type status;
   entry_type  result;
} alloc_response_type;

class fat_scoreboard;
   localparam int unsigned TABLE_SIZE = NUM_CLUSTERS_DEFAULT;

   entry_type          fat_image [TABLE_SIZE];
   int unsigned        scan_from;
   alloc_response_type awaited_responses[$];
   int                 mismatch_count;

   function new();
      foreach (fat_image[i]) fat_image[i] = '0;
      fat_image[0] = MEDIA_ENTRY;
      fat_image[1] = EOC_MARK;
      fat_image[2] = EOC_MARK;
      scan_from = 2;
      mismatch_count = 0;
   endfunction

   function void set_scan_start(cluster_type start);
      scan_from = start;
   endfunction

   function int outstanding();
      return awaited_responses.size();
   endfunction

   // Returns the claimed cluster, or zero when nothing is free at or above the scan start.
   function int unsigned claim_free_cluster();
      int unsigned c;
      c = (scan_from < 2) ? 2 : scan_from;
      for (; c < TABLE_SIZE; c++) begin
         if (fat_image[c] == '0) begin
            fat_image[c] = EOC_MIN;
            return c;
         end
      end
      return 0;
   endfunction

   function alloc_response_type note_request(func_type func, cluster_type cluster,
                                             entry_type value);
      alloc_response_type want;
      int unsigned        cur;
      int unsigned        steps;
      int unsigned        got;
      entry_type          link;
      bit                 broken;
      want.status = STAT_OK;
      want.result = '0;
      case (func)
         FUNC_READ: begin
            if (cluster >= TABLE_SIZE) want.status = STAT_RANGE;
            else want.result = fat_image[cluster];
         end
         FUNC_WRITE: begin
            if (cluster >= TABLE_SIZE) want.status = STAT_RANGE;
            else fat_image[cluster] = value;
         end
         FUNC_ALLOC: begin
            got = claim_free_cluster();
            if (got == 0) want.status = STAT_FULL;
            else want.result = entry_type'(got);
         end
         default: begin
            if (cluster < 2 || cluster >= TABLE_SIZE) begin
               want.status = STAT_BADSTART;
            end else begin
               cur = cluster;
               link = fat_image[cur];
               steps = 0;
               broken = 1'b0;
               // Walk to the end of the chain; bad links and runaway walks stop it.
               while (link < EOC_MIN && !broken) begin
                  if (link < 2 || link >= TABLE_SIZE || steps >= TABLE_SIZE) begin
                     broken = 1'b1;
                  end else begin
                     cur = link;
                     link = fat_image[cur];
                     steps++;
                  end
               end
               if (broken) begin
                  want.status = STAT_RANGE;
               end else begin
                  got = claim_free_cluster();
                  if (got == 0) begin
                     want.status = STAT_FULL;
                  end else begin
                     fat_image[cur] = entry_type'(got);
                     want.result = entry_type'(got);
                  end
               end
            end
         end
      endcase
      awaited_responses.push_back(want);
      return want;
   endfunction

   function void check_response(status_type status, entry_type result);
      alloc_response_type want;
      if (awaited_responses.size() == 0) begin
         $display("%0t: unexpected response: status %0d result %h", $time, status, result);
         mismatch_count++;
         return;
      end
      want = awaited_responses.pop_front();
      if (status !== want.status) begin
         $display("%0t: status mismatch: expected %0d, actual %0d",
                  $time, want.status, status);
         mismatch_count++;
      end
      if (result !== want.result) begin
         $display("%0t: result mismatch: expected %h, actual %h",
                  $time, want.result, result);
         mismatch_count++;
      end
   endfunction
endclass

module testbench;
   // Worst correct gap between handshakes: a cyclic walk plus a full scan,
   // the clearing pass after reset, or the long response hold-off.
   localparam int STALL_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   cluster_type csr_wdata = '0;

   fcca_req_if req_bus();
   fcca_rsp_if rsp_bus();

   fat_scoreboard      fat_board = new();
   alloc_response_type last_predicted;
   int                 items_sent = 0;
   int                 rsp_hold_cycles = 0;
   bit                 steady = 1'b0;

   fat_cluster_chain_allocator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic cluster_type pick_cluster();
      if ($urandom_range(0, 3) != 0) return cluster_type'($urandom_range(0, 47));
      return cluster_type'($urandom_range(0, 4095));
   endfunction

   function automatic entry_type pick_value();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return entry_type'($urandom_range(0, 47));
         2: return EOC_MIN + entry_type'($urandom_range(0, 7));
         3: return entry_type'($urandom_range(4096, 28'hFFFFFF7));
         4: return entry_type'(1);
         default: return entry_type'($urandom());
      endcase
   endfunction

   // Entered just after a rising edge; leaves valid high so back-to-back requests
   // need no second assignment in one time step.
   task automatic send_request(input func_type func, input cluster_type cluster,
                               input entry_type value);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.func    <= func;
      req_bus.cluster <= cluster;
      req_bus.value   <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      last_predicted = fat_board.note_request(func, cluster, value);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (fat_board.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_scan_start(input cluster_type start);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= start;
      @(posedge clock);
      fat_board.set_scan_start(start);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Allocate a head, extend it a few times, read it back and sometimes damage it.
   task automatic grow_chain();
      cluster_type head;
      cluster_type tail;
      send_request(FUNC_ALLOC, cluster_type'($urandom()), entry_type'($urandom()));
      if (last_predicted.status != STAT_OK) return;
      head = cluster_type'(last_predicted.result);
      tail = head;
      repeat ($urandom_range(1, 4)) begin
         send_request(FUNC_EXTEND, head, entry_type'($urandom()));
         if (last_predicted.status == STAT_OK) tail = cluster_type'(last_predicted.result);
      end
      send_request(FUNC_READ, head, entry_type'($urandom()));
      send_request(FUNC_READ, tail, entry_type'($urandom()));
      case ($urandom_range(0, 9))
         0: begin
            send_request(FUNC_WRITE, tail, {16'd0, head});
            send_request(FUNC_EXTEND, head, entry_type'($urandom()));
         end
         1: begin
            send_request(FUNC_WRITE, head, '0);
            send_request(FUNC_EXTEND, head, entry_type'($urandom()));
         end
         2: begin
            send_request(FUNC_WRITE, tail, EOC_MIN + entry_type'($urandom_range(0, 7)));
            send_request(FUNC_EXTEND, head, entry_type'($urandom()));
         end
         default: ;
      endcase
   endtask

   task automatic run_random_phase(input int count);
      int stop_at;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 15) == 0) steady = !steady;
         if ($urandom_range(0, 9) < 6) grow_chain();
         else send_request(func_type'($urandom_range(0, 3)), pick_cluster(), pick_value());
      end
      steady = 1'b0;
   endtask

   initial begin : response_sink
      int gap;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = pick_gap();
         end
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         fat_board.check_response(rsp_bus.status, rsp_bus.result);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      req_bus.valid   = 1'b0;
      req_bus.func    = FUNC_READ;
      req_bus.cluster = '0;
      req_bus.value   = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Formatted table, reserved clusters and the error paths of extend.
      write_scan_start('0);
      send_request(FUNC_READ, 12'd0, '0);
      send_request(FUNC_READ, 12'd1, '1);
      send_request(FUNC_READ, 12'd4095, '0);
      send_request(FUNC_ALLOC, 12'd0, '0);
      send_request(FUNC_EXTEND, 12'd0, '0);
      send_request(FUNC_EXTEND, 12'd1, '0);
      send_request(FUNC_EXTEND, 12'd3, '0);
      send_request(FUNC_READ, 12'd3, '0);
      send_request(FUNC_WRITE, 12'd4095, EOC_MARK);
      send_request(FUNC_READ, 12'd4095, '0);
      send_request(FUNC_WRITE, 12'd5, 28'hFFFFFF7);
      send_request(FUNC_EXTEND, 12'd5, '0);
      send_request(FUNC_WRITE, 12'd6, 28'd1);
      send_request(FUNC_EXTEND, 12'd6, '0);
      send_request(FUNC_EXTEND, 12'd7, '0);
      send_request(FUNC_WRITE, 12'd8, 28'd9);
      send_request(FUNC_WRITE, 12'd9, 28'd8);
      send_request(FUNC_EXTEND, 12'd8, '0);
      send_request(FUNC_WRITE, 12'd10, 28'h1000);
      send_request(FUNC_EXTEND, 12'd10, '0);
      send_request(FUNC_EXTEND, 12'd2, '0);
      send_request(FUNC_EXTEND, 12'd4095, '0);
      send_request(FUNC_WRITE, 12'd0, '0);
      send_request(FUNC_WRITE, 12'd1, '0);
      send_request(FUNC_ALLOC, 12'hFFF, '1);
      settle();

      // Scan starting at the last cluster: one success, then a full table.
      write_scan_start(12'd4095);
      send_request(FUNC_WRITE, 12'd4095, '0);
      send_request(FUNC_ALLOC, '0, '0);
      send_request(FUNC_ALLOC, '0, '0);
      send_request(FUNC_EXTEND, 12'd3, '0);
      send_request(FUNC_READ, 12'd4, '0);
      settle();

      write_scan_start(12'd1);
      run_random_phase(30);
      settle();

      // The response side stalls for a long stretch while requests keep coming.
      write_scan_start(cluster_type'($urandom_range(3, 200)));
      rsp_hold_cycles = 400;
      steady = 1'b1;
      repeat (8) send_request(FUNC_READ, pick_cluster(), entry_type'($urandom()));
      steady = 1'b0;
      run_random_phase(25);
      settle();

      write_scan_start(cluster_type'($urandom_range(4088, 4094)));
      run_random_phase(15);
      settle();

      write_scan_start(12'd2);
      run_random_phase(20);
      settle();

      repeat (64) @(negedge clock);
      if (fat_board.mismatch_count == 0 && fat_board.outstanding() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
